[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked with reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: expr");

// The consequent holds at the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante then cons");

`endif

[rtl/core/exlex_pkg.sv]
// ---------------------------------------------------------------------------
// Expression lexer package
// Token kinds, scan modes, character constants and character classes.
// ---------------------------------------------------------------------------
package exlex_pkg;

    localparam int unsigned MAX_LEN_DEFAULT = 4096;
    localparam logic [7:0]  SEPARATOR_RESET = 8'd32;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    typedef enum logic [2:0] {
        KIND_OP    = 3'd0,
        KIND_DELIM = 3'd1,
        KIND_NUM   = 3'd2,
        KIND_IDENT = 3'd3,
        KIND_ERR   = 3'd4
    } t_kind;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_INT    = 6'b000010,
        MODE_FRAC   = 6'b000100,
        MODE_DOT    = 6'b001000,
        MODE_DOTNUM = 6'b010000,
        MODE_IDENT  = 6'b100000
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] start;
        logic [12:0] len;
        logic [7:0]  symbol;
        logic        last;
    } t_token;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_EQUAL) || (c == CH_COLON);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
               (c == CH_RBRACK) || (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

    function automatic logic is_open(input t_mode m);
        logic r;
        case (m)
            MODE_INT, MODE_FRAC, MODE_DOT, MODE_DOTNUM, MODE_IDENT: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/expression_lexer.sv]
// ---------------------------------------------------------------------------
// Expression lexer
// Splits a character stream into operator, delimiter, number, identifier
// and error tokens.
// ---------------------------------------------------------------------------
// The lexer takes one character per item and gives an item's first token
// from an output register in the cycle after the item is taken; a second
// token waits in a one-entry holding stage behind it. It takes one item
// per cycle while the output side takes its tokens and no second token is
// held; an item with two tokens holds off the next item until its first
// is taken and the second is in the output register. The scan state is a
// single register set updated in the cycle an item is accepted. An item
// flagged as end of string flushes any open token and restarts positions at
// zero. The separator register may be written at any time the lexer is idle.
`include "assert_macros.svh"

module expression_lexer #(
    parameter int unsigned MAX_LEN = exlex_pkg::MAX_LEN_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_token_kind,
    output logic [11:0] o_start_index,
    output logic [12:0] o_token_length,
    output logic [7:0]  o_symbol,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned POS_W     = $clog2(MAX_LEN + 1);
    localparam int unsigned START_LIM = (MAX_LEN - 1 > 4095) ? 4095 : MAX_LEN - 1;

    function automatic exlex_pkg::t_token make_tok(
        input exlex_pkg::t_kind k,
        input logic [POS_W-1:0] start,
        input logic [POS_W-1:0] len,
        input logic [7:0]       sym
    );
        exlex_pkg::t_token t;
        logic [31:0] s32;
        logic [31:0] l32;
        s32 = 32'(start);
        l32 = 32'(len);
        if (s32 > 32'(START_LIM)) begin
            s32 = 32'(START_LIM);
        end
        t.kind   = k;
        t.start  = s32[11:0];
        t.len    = l32[12:0];
        t.symbol = sym;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic exlex_pkg::t_token close_tok(
        input exlex_pkg::t_mode  m,
        input logic [POS_W-1:0]  start,
        input logic [POS_W-1:0]  len
    );
        exlex_pkg::t_token t;
        case (m)
            exlex_pkg::MODE_DOT: begin
                t = make_tok(exlex_pkg::KIND_ERR, start, POS_W'(1), exlex_pkg::CH_DOT);
            end
            exlex_pkg::MODE_IDENT: begin
                t = make_tok(exlex_pkg::KIND_IDENT, start, len, 8'd0);
            end
            default: begin
                t = make_tok(exlex_pkg::KIND_NUM, start, len, 8'd0);
            end
        endcase
        return t;
    endfunction

    exlex_pkg::t_mode   r_mode, n_mode, mid_mode;
    logic [POS_W-1:0]   r_start, n_start, mid_start;
    logic [POS_W-1:0]   r_position, n_position;
    logic [POS_W-1:0]   r_tok_len, n_tok_len, mid_len;
    logic [7:0]         r_sep;

    exlex_pkg::t_token  r_out, r_hold;
    logic               r_out_valid, r_hold_valid;

    exlex_pkg::t_token  tok_a, tok_b, tok_c, tok_first, tok_second;
    logic               have_a, have_b, have_c, have_second;
    logic               used;
    logic               in_acc;

    assign in_acc      = i_valid && o_ready;
    assign o_ready     = (!r_out_valid || i_ready) && !r_hold_valid;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        used     = 1'b0;
        mid_mode = r_mode;
        case (r_mode)
            exlex_pkg::MODE_INT: begin
                if (exlex_pkg::is_digit(i_ch)) begin
                    used = 1'b1;
                end else if (i_ch == exlex_pkg::CH_DOT) begin
                    used     = 1'b1;
                    mid_mode = exlex_pkg::MODE_FRAC;
                end
            end
            exlex_pkg::MODE_FRAC, exlex_pkg::MODE_DOTNUM: begin
                used = exlex_pkg::is_digit(i_ch);
            end
            exlex_pkg::MODE_DOT: begin
                if (exlex_pkg::is_digit(i_ch)) begin
                    used     = 1'b1;
                    mid_mode = exlex_pkg::MODE_DOTNUM;
                end
            end
            exlex_pkg::MODE_IDENT: begin
                used = exlex_pkg::is_word(i_ch);
            end
            default: begin
                mid_mode = exlex_pkg::MODE_IDLE;
            end
        endcase

        mid_start = r_start;
        mid_len   = r_tok_len;
        have_a    = 1'b0;
        have_b    = 1'b0;
        tok_a     = close_tok(r_mode, r_start, r_tok_len);
        tok_b     = make_tok(exlex_pkg::KIND_ERR, r_position, POS_W'(1), i_ch);

        if (used) begin
            if (r_tok_len < POS_W'(MAX_LEN)) begin
                mid_len = r_tok_len + POS_W'(1);
            end
        end else begin
            have_a   = exlex_pkg::is_open(r_mode);
            mid_mode = exlex_pkg::MODE_IDLE;
            mid_len  = '0;
            if (i_ch == r_sep) begin
                have_b = 1'b0;
            end else if (exlex_pkg::is_op(i_ch)) begin
                have_b     = 1'b1;
                tok_b.kind = exlex_pkg::KIND_OP;
            end else if (exlex_pkg::is_delim(i_ch)) begin
                have_b     = 1'b1;
                tok_b.kind = exlex_pkg::KIND_DELIM;
            end else if (exlex_pkg::is_digit(i_ch)) begin
                mid_mode  = exlex_pkg::MODE_INT;
                mid_start = r_position;
                mid_len   = POS_W'(1);
            end else if (i_ch == exlex_pkg::CH_DOT) begin
                mid_mode  = exlex_pkg::MODE_DOT;
                mid_start = r_position;
                mid_len   = POS_W'(1);
            end else if (exlex_pkg::is_alpha(i_ch) || (i_ch == exlex_pkg::CH_UNDER)) begin
                mid_mode  = exlex_pkg::MODE_IDENT;
                mid_start = r_position;
                mid_len   = POS_W'(1);
            end else begin
                have_b = 1'b1;
            end
        end

        n_position = r_position;
        if (r_position < POS_W'(MAX_LEN)) begin
            n_position = r_position + POS_W'(1);
        end

        tok_c     = close_tok(mid_mode, mid_start, mid_len);
        have_c    = 1'b0;
        n_mode    = mid_mode;
        n_start   = mid_start;
        n_tok_len = mid_len;
        if (i_end_of_string) begin
            have_c     = exlex_pkg::is_open(mid_mode);
            n_mode     = exlex_pkg::MODE_IDLE;
            n_start    = '0;
            n_tok_len  = '0;
            n_position = '0;
        end

        have_second     = have_b || have_c;
        tok_second      = have_b ? tok_b : tok_c;
        tok_second.last = 1'b1;
        tok_first       = have_a ? tok_a : tok_second;
        tok_first.last  = !(have_a && have_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= exlex_pkg::MODE_IDLE;
            r_start    <= '0;
            r_position <= '0;
            r_tok_len  <= '0;
        end else if (in_acc) begin
            r_mode     <= n_mode;
            r_start    <= n_start;
            r_position <= n_position;
            r_tok_len  <= n_tok_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= exlex_pkg::SEPARATOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sep <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (in_acc && (have_a || have_second)) begin
            r_out_valid  <= 1'b1;
            r_hold_valid <= have_a && have_second;
        end else if (r_out_valid && i_ready) begin
            r_out_valid  <= r_hold_valid;
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (have_a || have_second)) begin
            r_out  <= tok_first;
            r_hold <= tok_second;
        end else if (r_out_valid && i_ready && r_hold_valid) begin
            r_out <= r_hold;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_token_kind   = r_out.kind;
    assign o_start_index  = r_out.start;
    assign o_token_length = r_out.len;
    assign o_symbol       = r_out.symbol;
    assign o_run_last     = r_out.last;

    `ASSERT_ALWAYS(a_hold_behind_out, i_clk, i_rst_n, !r_hold_valid || r_out_valid)
    `ASSERT_ALWAYS(a_no_accept_with_hold, i_clk, i_rst_n, !(in_acc && r_hold_valid))
    `ASSERT_ALWAYS(a_position_bound, i_clk, i_rst_n, r_position <= POS_W'(MAX_LEN))
    `ASSERT_NEXT(a_eos_restart, i_clk, i_rst_n, in_acc && i_end_of_string,
        (r_position == '0) && (r_mode == exlex_pkg::MODE_IDLE) && (r_tok_len == '0))

endmodule

[dv/expression_lexer_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Expression lexer checker
// Watches the character, token and separator channels of the lexer, works
// out the tokens that each accepted item should yield, and compares every
// delivered token with the oldest one still outstanding.
// ---------------------------------------------------------------------------
module expression_lexer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_eos,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_kind,
    input  logic [11:0] i_start,
    input  logic [12:0] i_length,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    import exlex_pkg::*;

    localparam logic [12:0] LEN_CAP   = 13'(MAX_LEN_DEFAULT);
    localparam logic [12:0] START_CAP = 13'd4095;

    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_ALPHA,
        CC_UNDER,
        CC_DOT,
        CC_OP,
        CC_DELIM,
        CC_OTHER
    } t_char_class;

    logic [7:0]  separator;
    t_mode       scan_st;
    logic [12:0] tok_first;
    logic [12:0] tok_count;
    logic [12:0] char_pos;
    t_token      step_tokens [0:1];
    int          step_count;
    t_token      expected_tokens [$];
    int          tokens_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        tokens_seen  = 0;
    end

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class cls;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CC_DIGIT;
        end else if ((c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
            cls = CC_ALPHA;
        end else if (c == CH_UNDER) begin
            cls = CC_UNDER;
        end else if (c == CH_DOT) begin
            cls = CC_DOT;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                     c == CH_EQUAL || c == CH_COLON) begin
            cls = CC_OP;
        end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
                     c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE) begin
            cls = CC_DELIM;
        end else begin
            cls = CC_OTHER;
        end
        return cls;
    endfunction

    task automatic report_failure(input string line);
        $display("ERROR at %0t: %s", $time, line);
        o_fail_count++;
    endtask

    task automatic add_token(input t_kind kind, input logic [12:0] first,
                             input logic [12:0] count, input logic [7:0] sym);
        t_token tok;
        tok.kind   = kind;
        tok.start  = (first > START_CAP) ? START_CAP[11:0] : first[11:0];
        tok.len    = count;
        tok.symbol = sym;
        tok.last   = 1'b0;
        step_tokens[step_count] = tok;
        step_count++;
    endtask

    task automatic close_open();
        case (scan_st)
            MODE_INT, MODE_FRAC, MODE_DOTNUM: begin
                add_token(KIND_NUM, tok_first, tok_count, 8'd0);
            end
            MODE_DOT: begin
                add_token(KIND_ERR, tok_first, 13'd1, CH_DOT);
            end
            MODE_IDENT: begin
                add_token(KIND_IDENT, tok_first, tok_count, 8'd0);
            end
            default: begin
            end
        endcase
        scan_st   = MODE_IDLE;
        tok_count = 13'd0;
    endtask

    task automatic open_token(input t_mode m);
        scan_st   = m;
        tok_first = char_pos;
        tok_count = 13'd1;
    endtask

    task automatic extend_token();
        if (tok_count < LEN_CAP) tok_count++;
    endtask

    task automatic lex_char(input logic [7:0] c, input logic eos);
        t_char_class cls;
        logic        taken;
        cls        = classify(c);
        taken      = 1'b0;
        step_count = 0;
        case (scan_st)
            MODE_INT: begin
                if (cls == CC_DIGIT || cls == CC_DOT) begin
                    extend_token();
                    if (cls == CC_DOT) scan_st = MODE_FRAC;
                    taken = 1'b1;
                end
            end
            MODE_FRAC, MODE_DOTNUM: begin
                if (cls == CC_DIGIT) begin
                    extend_token();
                    taken = 1'b1;
                end
            end
            MODE_DOT: begin
                if (cls == CC_DIGIT) begin
                    extend_token();
                    scan_st = MODE_DOTNUM;
                    taken   = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (cls == CC_DIGIT || cls == CC_ALPHA || cls == CC_UNDER) begin
                    extend_token();
                    taken = 1'b1;
                end
            end
            default: begin
                scan_st = MODE_IDLE;
            end
        endcase

        if (!taken) begin
            close_open();
            if (c != separator) begin
                case (cls)
                    CC_OP:    add_token(KIND_OP, char_pos, 13'd1, c);
                    CC_DELIM: add_token(KIND_DELIM, char_pos, 13'd1, c);
                    CC_DIGIT: open_token(MODE_INT);
                    CC_DOT:   open_token(MODE_DOT);
                    CC_ALPHA, CC_UNDER: open_token(MODE_IDENT);
                    default:  add_token(KIND_ERR, char_pos, 13'd1, c);
                endcase
            end
        end

        if (char_pos < LEN_CAP) char_pos++;

        if (eos) begin
            close_open();
            char_pos  = 13'd0;
            tok_first = 13'd0;
        end

        if (step_count > 0) step_tokens[step_count - 1].last = 1'b1;
        for (int k = 0; k < step_count; k++) expected_tokens = {expected_tokens, step_tokens[k]};
    endtask

    task automatic check_token();
        t_token want;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
            report_failure($sformatf("token %0d arrived with none outstanding (kind %0d)",
                                     tokens_seen, i_kind));
        end else begin
            want = expected_tokens.pop_front();
            if (i_kind !== want.kind)
                report_failure($sformatf("token %0d: kind %0d, expected %0d",
                                         tokens_seen, i_kind, want.kind));
            if (i_start !== want.start)
                report_failure($sformatf("token %0d: start %0d, expected %0d",
                                         tokens_seen, i_start, want.start));
            if (i_length !== want.len)
                report_failure($sformatf("token %0d: length %0d, expected %0d",
                                         tokens_seen, i_length, want.len));
            if (i_symbol !== want.symbol)
                report_failure($sformatf("token %0d: symbol %0h, expected %0h",
                                         tokens_seen, i_symbol, want.symbol));
            if (i_last !== want.last)
                report_failure($sformatf("token %0d: last flag %0b, expected %0b",
                                         tokens_seen, i_last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            separator = SEPARATOR_RESET;
            scan_st   = MODE_IDLE;
            tok_first = 13'd0;
            tok_count = 13'd0;
            char_pos  = 13'd0;
            expected_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_token();
            if (i_in_valid && i_in_ready) lex_char(i_ch, i_eos);
            if (i_cfg_valid && i_cfg_ready) separator = i_cfg_data;
        end
        o_pending = expected_tokens.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Expression lexer testbench
// Drives character strings into the lexer under several separator settings
// and idling patterns, ending with a long identifier, an operator and a
// number, while the checker predicts and compares every token.
// ---------------------------------------------------------------------------
module tb_top;

    import exlex_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 110;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_ch;
    logic        i_end_of_string;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_token_kind;
    logic [11:0] o_start_index;
    logic [12:0] o_token_length;
    logic [7:0]  o_symbol;
    logic        o_run_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    int          fail_count;
    int          tokens_pending;
    int          items_sent = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [7:0]  sep_now = SEPARATOR_RESET;
    string       directed_text;
    string       digit_sep_text;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    expression_lexer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_ch            (i_ch),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_token_kind    (o_token_kind),
        .o_start_index   (o_start_index),
        .o_token_length  (o_token_length),
        .o_symbol        (o_symbol),
        .o_run_last      (o_run_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    expression_lexer_checker token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_ch         (i_ch),
        .i_eos        (i_end_of_string),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_kind       (o_token_kind),
        .i_start      (o_start_index),
        .i_length     (o_token_length),
        .i_symbol     (o_symbol),
        .i_last       (o_run_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (tokens_pending)
    );

    // The token side either stalls at random or holds off for a long
    // stretch, so that the lexer fills up and refuses further items.
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = CH_ZERO + 8'($urandom_range(9));
            1:       c = CH_LOW_A + 8'($urandom_range(25));
            2:       c = CH_UP_A + 8'($urandom_range(25));
            default: c = CH_UNDER;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] op_char();
        logic [7:0] c;
        case ($urandom_range(5))
            0:       c = CH_PLUS;
            1:       c = CH_MINUS;
            2:       c = CH_STAR;
            3:       c = CH_SLASH;
            4:       c = CH_EQUAL;
            default: c = CH_COLON;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] delim_char();
        logic [7:0] c;
        case ($urandom_range(5))
            0:       c = CH_LPAREN;
            1:       c = CH_RPAREN;
            2:       c = CH_LBRACK;
            3:       c = CH_RBRACK;
            4:       c = CH_LBRACE;
            default: c = CH_RBRACE;
        endcase
        return c;
    endfunction

    // Mostly expression-like text, with some raw bytes as noise.
    function automatic logic [7:0] pick_char(input logic [7:0] sep);
        int unsigned roll;
        logic [7:0]  c;
        roll = $urandom_range(99);
        if (roll < 24) begin
            c = CH_ZERO + 8'($urandom_range(9));
        end else if (roll < 44) begin
            c = word_char();
        end else if (roll < 56) begin
            c = CH_DOT;
        end else if (roll < 66) begin
            c = op_char();
        end else if (roll < 74) begin
            c = delim_char();
        end else if (roll < 86) begin
            c = sep;
        end else begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eos);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_ch            <= c;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) send_char(text[k], k == text.len() - 1);
    endtask

    task automatic send_random_string();
        int n;
        n = $urandom_range(24, 1);
        for (int k = 0; k < n; k++) send_char(pick_char(sep_now), k == n - 1);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tokens_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        sep_now = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int gap, input int stall);
        int first_item;
        gap_pct    = gap;
        stall_pct  = stall;
        first_item = items_sent;
        while (items_sent - first_item < PHASE_ITEMS) send_random_string();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ch            = 8'd0;
        i_end_of_string = 1'b0;
        i_ready         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 8'd0;
        directed_text   = "_z9 =.5.3*1.2.3/(.)[]{}-:+";
        digit_sep_text  = "155a5+5";
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_separator(SEPARATOR_RESET);
        for (int k = 0; k < directed_text.len(); k++) send_char(directed_text[k], 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_UP_A + 8'd16, 1'b1);

        write_separator(CH_ZERO + 8'd5);
        send_text(digit_sep_text);
        random_phase(49, 0);

        write_separator(8'h00);
        random_phase(0, 49);

        write_separator(8'hFF);
        random_phase(16, 16);

        write_separator(CH_DOT);
        holds_asked++;
        random_phase(0, 0);

        // A long identifier, then an operator and a number that ends the
        // string.
        write_separator(SEPARATOR_RESET);
        send_char(CH_LOW_A + 8'd10, 1'b0);
        for (int k = 0; k < 40; k++) send_char(word_char(), 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_ZERO + 8'd7, 1'b0);
        send_char(CH_ZERO + 8'd8, 1'b1);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[expression_lexer.f]
+incdir+rtl/core
rtl/core/exlex_pkg.sv
rtl/core/expression_lexer.sv
dv/expression_lexer_checker.sv
dv/tb_top.sv
